/* rtl/core/dtesc_pkg.sv */
// Shared types and constants for the dual track encoder speed controller.
// Used by the controller, the datapath and the top level; no dependencies.
package dtesc_pkg;

   localparam int DEF_POSITION_BITS       = 32;
   localparam int DEF_SPEED_FRACTION_BITS = 8;

   localparam int TARGET_BITS = 32;
   localparam int GAIN_BITS   = 16;
   localparam int SPEED_BITS  = 16;
   localparam int ELAPSED_BITS = 16;
   localparam int ERR_BITS    = SPEED_BITS + 1;
   localparam int PROD_BITS   = ERR_BITS + GAIN_BITS + 1;
   localparam int PWM_BITS    = 8;

   // speed quotient: 17 bits decide saturation, larger values saturate early
   localparam int QUO_BITS        = 17;
   localparam int SPEED_SAT_SHIFT = 40;
   localparam logic [QUO_BITS-1:0] SPEED_POS_LIMIT = QUO_BITS'(32767);
   localparam logic [QUO_BITS-1:0] SPEED_NEG_LIMIT = QUO_BITS'(32768);
   localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = 16'sh7fff;
   localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = 16'sh8000;
   localparam int DUTY_MAX = 255;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd12800;

   localparam int CMD_BITS = 3;
   localparam logic [CMD_BITS-1:0] CMD_EDGE      = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_TICK      = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_ENABLE    = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CLR_FLAGS = 3'd4;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LEFT_TARGET  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RIGHT_TARGET = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LEFT_GAIN    = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RIGHT_GAIN   = 2'd3;

   localparam int REQ_TUSER_BITS = 4;
   localparam int REQ_TDATA_BITS = 56;
   localparam int RSP_TDATA_BITS = 88;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_EDGE_STEP,
      DP_EDGE_CHECK,
      DP_ENABLE,
      DP_CLEAR,
      DP_CLR_FLAGS,
      DP_DIFF,
      DP_MAG,
      DP_LOAD,
      DP_DIV,
      DP_ERR,
      DP_MUL,
      DP_ACC,
      DP_SNAP,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      side;   // tick track: 0 left, 1 right
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_sts_type;

endpackage

/* rtl/core/dtesc_ctrl.sv */
// Sequencer for the dual track encoder speed controller.
// Issues datapath commands and owns the request/response handshake; uses dtesc_pkg.
module dtesc_ctrl import dtesc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CMD_BITS-1:0] req_command,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output dp_cmd_type          cmd,
   input  dp_sts_type          sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_STEP,
      S_EDGE_CHECK,
      S_ONE_SHOT,
      S_DIFF,
      S_MAG,
      S_LOAD,
      S_DIV,
      S_ERR,
      S_MUL,
      S_ACC,
      S_SNAP,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic                side_ff, side_in;
   logic [CMD_BITS-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dp_op_type           op;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      code_in      = code_ff;
      op           = DP_NOP;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               op      = DP_CAPTURE;
               code_in = req_command;
               side_in = 1'b0;
               if (req_command == CMD_EDGE) begin
                  state_in = S_EDGE_STEP;
               end else if (req_command == CMD_TICK) begin
                  state_in = S_DIFF;
               end else begin
                  state_in = S_ONE_SHOT;
               end
            end
         end
         S_EDGE_STEP: begin
            op       = DP_EDGE_STEP;
            state_in = S_EDGE_CHECK;
         end
         S_EDGE_CHECK: begin
            op       = DP_EDGE_CHECK;
            state_in = S_DONE;
         end
         S_ONE_SHOT: begin
            unique case (code_ff)
               CMD_ENABLE:    op = DP_ENABLE;
               CMD_CLEAR:     op = DP_CLEAR;
               CMD_CLR_FLAGS: op = DP_CLR_FLAGS;
               default:       op = DP_NOP;
            endcase
            state_in = S_DONE;
         end
         S_DIFF: begin
            op       = DP_DIFF;
            state_in = S_MAG;
         end
         S_MAG: begin
            op       = DP_MAG;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            op       = DP_LOAD;
            state_in = S_DIV;
         end
         S_DIV: begin
            op = DP_DIV;
            if (sts.div_last) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            op       = DP_ERR;
            state_in = S_MUL;
         end
         S_MUL: begin
            op       = DP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            op = DP_ACC;
            if (side_ff) begin
               state_in = S_SNAP;
            end else begin
               side_in  = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_SNAP: begin
            op       = DP_SNAP;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               op           = DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= 1'b0;
         code_ff      <= CMD_EDGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign cmd.op     = op;
   assign cmd.side   = side_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_div_exits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && sts.div_last) |=> (state_ff == S_ERR))
      else $error("divider finished but sequencer did not move on");

   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      (op == DP_PUBLISH) |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      (op == DP_PUBLISH) |=> rsp_valid_ff)
      else $error("published response not flagged valid");

   a_right_after_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && !side_ff) |=> (state_ff == S_DIFF && side_ff))
      else $error("right track not processed after left track");

endmodule

/* rtl/core/dtesc_dp.sv */
// Datapath: configuration, encoder counts, shared speed divider,
// shared gain multiplier and duty accumulators. Uses dtesc_pkg.
module dtesc_dp import dtesc_pkg::*; #(
   parameter int POSITION_BITS       = DEF_POSITION_BITS,
   parameter int SPEED_FRACTION_BITS = DEF_SPEED_FRACTION_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   output dp_sts_type                     sts,
   input  logic                           req_track,
   input  logic                           req_phase_b,
   input  logic [ELAPSED_BITS-1:0]        req_elapsed_ms,
   input  logic signed [SPEED_BITS-1:0]   req_left_speed_target,
   input  logic signed [SPEED_BITS-1:0]   req_right_speed_target,
   input  logic                           csr_we,
   input  logic [CSR_ADDR_BITS-1:0]       csr_addr,
   input  logic [CSR_DATA_BITS-1:0]       csr_wdata,
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata
);

   localparam int PB       = POSITION_BITS;
   localparam int SFB      = SPEED_FRACTION_BITS;
   localparam int CW       = (PB > TARGET_BITS) ? PB : TARGET_BITS;
   localparam int MAGW     = (PB < SPEED_SAT_SHIFT) ? PB : SPEED_SAT_SHIFT;
   localparam int DW       = MAGW + SFB;
   localparam int ACC_FRAC = SFB + 8;
   localparam int AW       = ACC_FRAC + PWM_BITS;
   localparam int SW       = ((AW > PROD_BITS) ? AW : PROD_BITS) + 1;
   localparam int QCW      = $clog2(QUO_BITS);
   localparam logic [AW-1:0] ACC_MAX = AW'(DUTY_MAX) << ACC_FRAC;

   // configuration
   logic [TARGET_BITS-1:0] ltgt_ff, ltgt_in, rtgt_ff, rtgt_in;
   logic [GAIN_BITS-1:0]   lgain_ff, lgain_in, rgain_ff, rgain_in;
   // architectural state
   logic [PB-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [PB-1:0] lprev_ff, lprev_in, rprev_ff, rprev_in;
   logic [AW-1:0] lacc_ff, lacc_in, racc_ff, racc_in;
   logic          lreach_ff, lreach_in, rreach_ff, rreach_in;
   logic          ldrv_ff, ldrv_in, rdrv_ff, rdrv_in;
   logic [QCW-1:0] div_cnt_ff, div_cnt_in;
   // request payload and work registers
   logic                         track_ff, track_in, phase_ff, phase_in;
   logic [ELAPSED_BITS-1:0]      el_ff, el_in;
   logic signed [SPEED_BITS-1:0] lspt_ff, lspt_in, rspt_ff, rspt_in;
   logic [PB-1:0]                diff_ff, diff_in, mag_ff, mag_in;
   logic                         neg_ff, neg_in, sat_ff, sat_in;
   logic [ELAPSED_BITS-1:0]      rem_ff, rem_in;
   logic [QUO_BITS-1:0]          dsh_ff, dsh_in, quo_ff, quo_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [RSP_TDATA_BITS-1:0]    rsp_ff, rsp_in;

   // combinational helpers
   logic [PB-1:0]                edge_cnt, edge_next, tick_cnt, tick_prev;
   logic [TARGET_BITS-1:0]       edge_tgt;
   logic signed [CW-1:0]         cnt_ext, tgt_ext, lpos_ext, rpos_ext;
   logic                         edge_reach;
   logic [DW-1:0]                dvd, dvd_hi;
   logic                         huge;
   logic [ELAPSED_BITS:0]        trial;
   logic                         trial_ok;
   logic signed [SPEED_BITS-1:0] speed, tick_spt;
   logic [GAIN_BITS-1:0]         tick_gain;
   logic [AW-1:0]                tick_acc, acc_new;
   logic signed [SW-1:0]         acc_sum;

   always_comb begin
      edge_cnt   = track_ff ? rcnt_ff : lcnt_ff;
      edge_tgt   = track_ff ? rtgt_ff : ltgt_ff;
      edge_next  = phase_ff ? edge_cnt - PB'(1) : edge_cnt + PB'(1);
      cnt_ext    = CW'($signed(edge_cnt));
      tgt_ext    = CW'($signed(edge_tgt));
      edge_reach = cnt_ext >= tgt_ext;

      tick_cnt  = cmd.side ? rcnt_ff : lcnt_ff;
      tick_prev = cmd.side ? rprev_ff : lprev_ff;
      tick_spt  = cmd.side ? rspt_ff : lspt_ff;
      tick_gain = cmd.side ? rgain_ff : lgain_ff;
      tick_acc  = cmd.side ? racc_ff : lacc_ff;

      huge   = (mag_ff >> SPEED_SAT_SHIFT) != '0;
      dvd    = DW'(mag_ff) << SFB;
      dvd_hi = dvd >> QUO_BITS;

      trial    = {rem_ff, dsh_ff[QUO_BITS-1]};
      trial_ok = trial >= {1'b0, el_ff};

      if (sat_ff) begin
         speed = neg_ff ? SPEED_MIN : SPEED_MAX;
      end else if (neg_ff) begin
         speed = (quo_ff > SPEED_NEG_LIMIT) ? SPEED_MIN : SPEED_BITS'(-quo_ff);
      end else begin
         speed = (quo_ff > SPEED_POS_LIMIT) ? SPEED_MAX : SPEED_BITS'(quo_ff);
      end

      acc_sum = $signed(SW'(tick_acc)) + SW'(prod_ff);
      if (acc_sum < 0) begin
         acc_new = '0;
      end else if (acc_sum > $signed(SW'(ACC_MAX))) begin
         acc_new = ACC_MAX;
      end else begin
         acc_new = AW'(acc_sum);
      end

      lpos_ext = CW'($signed(lcnt_ff));
      rpos_ext = CW'($signed(rcnt_ff));
   end

   always_comb begin
      ltgt_in    = ltgt_ff;
      rtgt_in    = rtgt_ff;
      lgain_in   = lgain_ff;
      rgain_in   = rgain_ff;
      lcnt_in    = lcnt_ff;
      rcnt_in    = rcnt_ff;
      lprev_in   = lprev_ff;
      rprev_in   = rprev_ff;
      lacc_in    = lacc_ff;
      racc_in    = racc_ff;
      lreach_in  = lreach_ff;
      rreach_in  = rreach_ff;
      ldrv_in    = ldrv_ff;
      rdrv_in    = rdrv_ff;
      div_cnt_in = div_cnt_ff;
      track_in   = track_ff;
      phase_in   = phase_ff;
      el_in      = el_ff;
      lspt_in    = lspt_ff;
      rspt_in    = rspt_ff;
      diff_in    = diff_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      err_in     = err_ff;
      prod_in    = prod_ff;
      rsp_in     = rsp_ff;

      if (csr_we) begin
         unique case (csr_addr)
            REG_LEFT_TARGET:  ltgt_in  = csr_wdata;
            REG_RIGHT_TARGET: rtgt_in  = csr_wdata;
            REG_LEFT_GAIN:    lgain_in = GAIN_BITS'(csr_wdata);
            REG_RIGHT_GAIN:   rgain_in = GAIN_BITS'(csr_wdata);
            default: ;
         endcase
      end

      unique case (cmd.op)
         DP_CAPTURE: begin
            track_in = req_track;
            phase_in = req_phase_b;
            el_in    = (req_elapsed_ms == '0) ? ELAPSED_BITS'(1) : req_elapsed_ms;
            lspt_in  = req_left_speed_target;
            rspt_in  = req_right_speed_target;
         end
         DP_EDGE_STEP: begin
            if (track_ff) begin
               rcnt_in = edge_next;
            end else begin
               lcnt_in = edge_next;
            end
         end
         DP_EDGE_CHECK: begin
            if (track_ff) begin
               if (edge_reach && !rreach_ff) begin
                  rreach_in = 1'b1;
                  rdrv_in   = 1'b0;
               end
            end else begin
               if (edge_reach && !lreach_ff) begin
                  lreach_in = 1'b1;
                  ldrv_in   = 1'b0;
               end
            end
         end
         DP_ENABLE: begin
            ldrv_in  = 1'b1;
            rdrv_in  = 1'b1;
            lacc_in  = '0;
            racc_in  = '0;
            lprev_in = lcnt_ff;
            rprev_in = rcnt_ff;
         end
         DP_CLEAR: begin
            lcnt_in = '0;
            rcnt_in = '0;
         end
         DP_CLR_FLAGS: begin
            lreach_in = 1'b0;
            rreach_in = 1'b0;
         end
         DP_DIFF: diff_in = tick_cnt - tick_prev;
         DP_MAG: begin
            neg_in = diff_ff[PB-1];
            mag_in = diff_ff[PB-1] ? -diff_ff : diff_ff;
         end
         DP_LOAD: begin
            // quotient of 2^17 or more saturates either way
            sat_in     = huge || (dvd_hi >= DW'(el_ff));
            rem_in     = ELAPSED_BITS'(dvd_hi);
            dsh_in     = dvd[QUO_BITS-1:0];
            quo_in     = '0;
            div_cnt_in = '0;
         end
         DP_DIV: begin
            rem_in     = trial_ok ? ELAPSED_BITS'(trial - {1'b0, el_ff})
                                  : ELAPSED_BITS'(trial);
            quo_in     = {quo_ff[QUO_BITS-2:0], trial_ok};
            dsh_in     = dsh_ff << 1;
            div_cnt_in = div_cnt_ff + QCW'(1);
         end
         DP_ERR: err_in = ERR_BITS'(tick_spt) - ERR_BITS'(speed);
         DP_MUL: prod_in = PROD_BITS'(err_ff) * PROD_BITS'($signed({1'b0, tick_gain}));
         DP_ACC: begin
            if (cmd.side) begin
               racc_in = acc_new;
            end else begin
               lacc_in = acc_new;
            end
         end
         DP_SNAP: begin
            lprev_in = lcnt_ff;
            rprev_in = rcnt_ff;
         end
         DP_PUBLISH: begin
            rsp_in = RSP_TDATA_BITS'({lreach_ff && rreach_ff,
                                      rpos_ext[TARGET_BITS-1:0],
                                      lpos_ext[TARGET_BITS-1:0],
                                      rdrv_ff, ldrv_ff,
                                      racc_ff[AW-1:ACC_FRAC],
                                      lacc_ff[AW-1:ACC_FRAC]});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ltgt_ff    <= '0;
         rtgt_ff    <= '0;
         lgain_ff   <= GAIN_RESET;
         rgain_ff   <= GAIN_RESET;
         lcnt_ff    <= '0;
         rcnt_ff    <= '0;
         lprev_ff   <= '0;
         rprev_ff   <= '0;
         lacc_ff    <= '0;
         racc_ff    <= '0;
         lreach_ff  <= 1'b0;
         rreach_ff  <= 1'b0;
         ldrv_ff    <= 1'b0;
         rdrv_ff    <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         ltgt_ff    <= ltgt_in;
         rtgt_ff    <= rtgt_in;
         lgain_ff   <= lgain_in;
         rgain_ff   <= rgain_in;
         lcnt_ff    <= lcnt_in;
         rcnt_ff    <= rcnt_in;
         lprev_ff   <= lprev_in;
         rprev_ff   <= rprev_in;
         lacc_ff    <= lacc_in;
         racc_ff    <= racc_in;
         lreach_ff  <= lreach_in;
         rreach_ff  <= rreach_in;
         ldrv_ff    <= ldrv_in;
         rdrv_ff    <= rdrv_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      track_ff <= track_in;
      phase_ff <= phase_in;
      el_ff    <= el_in;
      lspt_ff  <= lspt_in;
      rspt_ff  <= rspt_in;
      diff_ff  <= diff_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      err_ff   <= err_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.div_last = div_cnt_ff == QCW'(QUO_BITS - 1);
   assign rsp_tdata    = rsp_ff;

endmodule

/* rtl/core/dual_track_encoder_speed_controller_top.sv */
// Sequence: an encoder edge is captured, stepped and checked, and enable/clear/flag
// commands are captured and executed, before the response is published; a control
// tick runs the 17-step shared speed divider once per track plus multiply and add.
// One request in flight: a new request is accepted only after the response to the
// previous one has been published.
// Reset (synchronous): counts, snapshots, duty and flags zero, drives off, targets 0, gains 50.0.
module dual_track_encoder_speed_controller_top import dtesc_pkg::*; #(
   parameter int POSITION_BITS       = DEF_POSITION_BITS,
   parameter int SPEED_FRACTION_BITS = DEF_SPEED_FRACTION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] phase_b, [16:1] elapsed_ms, [32:17] left_speed_target,
   // [48:33] right_speed_target, rest zero
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // [2:0] command, [3] track_select
   input  logic [REQ_TUSER_BITS-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [7:0] left_pwm, [15:8] right_pwm, [16] left_drive_on, [17] right_drive_on,
   // [49:18] left_position, [81:50] right_position, [82] both_at_target, rest zero
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   dtesc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser[CMD_BITS-1:0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .sts         (sts)
   );

   dtesc_dp #(
      .POSITION_BITS       (POSITION_BITS),
      .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_track              (req_tuser[CMD_BITS]),
      .req_phase_b            (req_tdata[0]),
      .req_elapsed_ms         (req_tdata[16:1]),
      .req_left_speed_target  ($signed(req_tdata[32:17])),
      .req_right_speed_target ($signed(req_tdata[48:33])),
      .csr_we                 (csr_we),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata),
      .rsp_tdata              (rsp_tdata)
   );

endmodule
